@@ rtl/lae_pkg.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lae_pkg: shared types and constants of the Lorenz oscillator
// Widths, register reset values, item modes, the controller's command word
// and the datapath's status word.
// -----------------------------------------------------------------------------
package lae_pkg;

   localparam int IO_WIDTH        = 32;  // state words on the ports
   localparam int COEF_WIDTH      = 32;  // sigma, rho, beta
   localparam int COEF_FRAC       = 20;
   localparam int STEP_WIDTH      = 24;  // h as an unsigned fraction
   localparam int STEP_FRAC       = 24;
   localparam int GUARD_BITS      = 15;  // headroom of derivative terms
   localparam int MUL_DIGIT       = 16;  // multiplier digit per cycle
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int FRAC_BITS_DEF   = 20;
   localparam int STATE_WIDTH_DEF = 32;

   localparam logic [COEF_WIDTH-1:0] SIGMA_RESET = 32'd10485760;  // 10.0
   localparam logic [COEF_WIDTH-1:0] RHO_RESET   = 32'd29360128;  // 28.0
   localparam logic [COEF_WIDTH-1:0] BETA_RESET  = 32'd2796203;   // 8/3
   localparam logic [STEP_WIDTH-1:0] STEP_RESET  = 24'd38045;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_SIGMA = 2'd0,
      CSR_RHO   = 2'd1,
      CSR_BETA  = 2'd2,
      CSR_STEP  = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_TICK    = 2'd0,
      MODE_LOAD    = 2'd1,
      MODE_RESTART = 2'd2
   } mode_type;

   // One multiply per operation, in the order the controller walks them.
   typedef enum logic [2:0] {
      OP_DX  = 3'd0,  // sigma * (y - x)
      OP_PXR = 3'd1,  // x * (rho - z)
      OP_PXY = 3'd2,  // x * y
      OP_BZ  = 3'd3,  // beta * z
      OP_HX  = 3'd4,  // h * dx
      OP_HY  = 3'd5,  // h * dy
      OP_HZ  = 3'd6   // h * dz, then commit
   } op_type;

   typedef enum logic [1:0] {
      SH_COEF = 2'd0,
      SH_FRAC = 2'd1,
      SH_STEP = 2'd2
   } shift_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_START = 2'd1,
      ST_WAIT  = 2'd2,
      ST_DONE  = 2'd3
   } ctrl_state_type;

   typedef struct packed {
      logic     accept;
      mode_type mode;
      logic     mul_start;
      logic     write;
      op_type   op;
      logic     publish;
   } cmd_type;

   typedef struct packed {
      logic mul_busy;
      logic mul_done;
   } status_type;

endpackage

@@ rtl/lae_mul.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lae_mul: shared digit-serial fractional multiplier
// Sign-magnitude product, one 16-bit digit of B per cycle, then floor shift
// and saturation to the derivative width.
// -----------------------------------------------------------------------------
module lae_mul #(
   parameter int OW        = 47,
   parameter int DW        = 47,
   parameter int FRAC_BITS = 20
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  lae_pkg::shift_type     shift,
   input  logic signed [OW-1:0]   op_a,
   input  logic signed [OW-1:0]   op_b,
   output logic                   busy,
   output logic                   done,
   output logic signed [DW-1:0]   result
);
   import lae_pkg::*;

   localparam int ND  = (OW + MUL_DIGIT - 1) / MUL_DIGIT;
   localparam int NDW = ND * MUL_DIGIT;
   localparam int PW  = OW + NDW;
   localparam int CW  = $clog2(ND + 1);
   localparam int TW  = PW - DW + 1;
   localparam logic signed [DW-1:0] DMAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [DW-1:0] DMIN = {1'b1, {(DW-1){1'b0}}};

   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 rnd_ff, rnd_in;
   logic                 fin_ff, fin_in;
   logic                 done_ff, done_in;
   logic [OW-1:0]        ua_ff, ua_in;
   logic [NDW-1:0]       ub_ff, ub_in;
   logic                 neg_ff, neg_in;
   shift_type            shift_ff, shift_in;
   logic [PW-1:0]        acc_ff, acc_in;
   logic [PW-1:0]        q_ff, q_in;
   logic signed [DW-1:0] res_ff, res_in;
   logic [OW+MUL_DIGIT-1:0] part;
   logic [PW-1:0]        shifted;
   logic                 rem;
   logic [TW-1:0]        q_top;
   logic                 over;
   logic                 at_min;

   assign part = (OW + MUL_DIGIT)'(ua_ff) * (OW + MUL_DIGIT)'(ub_ff[NDW-1 -: MUL_DIGIT]);

   always_comb begin
      case (shift_ff)
         SH_COEF: begin
            shifted = acc_ff >> COEF_FRAC;
            rem     = |acc_ff[COEF_FRAC-1:0];
         end
         SH_FRAC: begin
            shifted = acc_ff >> FRAC_BITS;
            rem     = |acc_ff[FRAC_BITS-1:0];
         end
         default: begin
            shifted = acc_ff >> STEP_FRAC;
            rem     = |acc_ff[STEP_FRAC-1:0];
         end
      endcase
   end

   assign q_top  = q_ff[PW-1:DW-1];
   assign over   = (q_top != '0);
   assign at_min = (q_top == TW'(1)) && (q_ff[DW-2:0] == '0);

   always_comb begin
      cnt_in   = cnt_ff;
      ua_in    = ua_ff;
      ub_in    = ub_ff;
      neg_in   = neg_ff;
      shift_in = shift_ff;
      acc_in   = acc_ff;
      rnd_in   = 1'b0;
      fin_in   = rnd_ff;
      done_in  = fin_ff;
      q_in     = q_ff;
      res_in   = res_ff;
      if (start) begin
         cnt_in   = CW'(ND);
         ua_in    = op_a[OW-1] ? unsigned'(-op_a) : unsigned'(op_a);
         ub_in    = NDW'(op_b[OW-1] ? unsigned'(-op_b) : unsigned'(op_b));
         neg_in   = op_a[OW-1] ^ op_b[OW-1];
         shift_in = shift;
         acc_in   = '0;
      end else if (cnt_ff != '0) begin
         acc_in = (acc_ff << MUL_DIGIT) + PW'(part);
         ub_in  = ub_ff << MUL_DIGIT;
         cnt_in = cnt_ff - CW'(1);
         rnd_in = (cnt_ff == CW'(1));
      end
      // floor: a negative product with dropped bits rounds away from zero
      if (rnd_ff) begin
         q_in = shifted + PW'(neg_ff && rem);
      end
      if (fin_ff) begin
         if (!neg_ff) begin
            res_in = over ? DMAX : signed'(q_ff[DW-1:0]);
         end else begin
            res_in = (over && !at_min) ? DMIN : -signed'(q_ff[DW-1:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         rnd_ff  <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         rnd_ff  <= rnd_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      ua_ff    <= ua_in;
      ub_ff    <= ub_in;
      neg_ff   <= neg_in;
      shift_ff <= shift_in;
      acc_ff   <= acc_in;
      q_ff     <= q_in;
      res_ff   <= res_in;
   end

   assign busy   = (cnt_ff != '0) || rnd_ff || fin_ff;
   assign done   = done_ff;
   assign result = res_ff;

endmodule

@@ rtl/lae_datapath.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lae_datapath: state, coefficients and Euler arithmetic
// Holds x, y, z and the registers, feeds the shared multiplier and writes
// its results back as the controller commands.
// -----------------------------------------------------------------------------
module lae_datapath #(
   parameter int FRAC_BITS   = 20,
   parameter int STATE_WIDTH = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  lae_pkg::cmd_type                       cmd,
   output lae_pkg::status_type                    status,
   input  logic                                   csr_wr_en,
   input  logic [lae_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [lae_pkg::COEF_WIDTH-1:0]         csr_wr_data,
   input  logic signed [lae_pkg::IO_WIDTH-1:0]    req_load_x,
   input  logic signed [lae_pkg::IO_WIDTH-1:0]    req_load_y,
   input  logic signed [lae_pkg::IO_WIDTH-1:0]    req_load_z,
   output logic signed [lae_pkg::IO_WIDTH-1:0]    rsp_pos_x,
   output logic signed [lae_pkg::IO_WIDTH-1:0]    rsp_pos_y,
   output logic signed [lae_pkg::IO_WIDTH-1:0]    rsp_pos_z,
   output logic                                   rsp_saturated
);
   import lae_pkg::*;

   localparam int SW    = STATE_WIDTH;
   localparam int DW    = SW + GUARD_BITS;
   localparam int RSH_L = (FRAC_BITS > COEF_FRAC) ? FRAC_BITS - COEF_FRAC : 0;
   localparam int RSH_R = (FRAC_BITS < COEF_FRAC) ? COEF_FRAC - FRAC_BITS : 0;
   localparam int RW    = COEF_WIDTH + RSH_L;
   localparam int RZW   = ((RW > SW) ? RW : SW) + 1;
   localparam int OW    = (DW > RZW) ? DW : RZW;
   localparam int LW    = (SW > IO_WIDTH) ? SW : IO_WIDTH;
   localparam logic signed [SW-1:0] SMAX    = {1'b0, {(SW-1){1'b1}}};
   localparam logic signed [SW-1:0] SMIN    = {1'b1, {(SW-1){1'b0}}};
   localparam logic signed [DW-1:0] DMAX    = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [DW-1:0] DMIN    = {1'b1, {(DW-1){1'b0}}};
   localparam logic signed [SW-1:0] START_X = SW'(longint'(1) << (FRAC_BITS - 1));

   function automatic logic fits_sw(input logic [DW:0] v);
      return (v[DW:SW-1] == '0) || (v[DW:SW-1] == '1);
   endfunction

   function automatic logic signed [SW-1:0] clamp_sw(input logic [DW:0] v);
      logic signed [SW-1:0] r;
      if (fits_sw(v)) r = signed'(v[SW-1:0]);
      else            r = v[DW] ? SMIN : SMAX;
      return r;
   endfunction

   function automatic logic signed [DW-1:0] clamp_dw(input logic [DW:0] v);
      logic signed [DW-1:0] r;
      if (v[DW] == v[DW-1]) r = signed'(v[DW-1:0]);
      else                  r = v[DW] ? DMIN : DMAX;
      return r;
   endfunction

   logic signed [COEF_WIDTH-1:0] sigma_ff, sigma_in;
   logic signed [COEF_WIDTH-1:0] rho_ff, rho_in;
   logic signed [COEF_WIDTH-1:0] beta_ff, beta_in;
   logic [STEP_WIDTH-1:0]        step_ff, step_in;
   logic signed [SW-1:0]         x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic signed [SW-1:0]         nx_ff, nx_in, ny_ff, ny_in;
   logic signed [DW-1:0]         dx_ff, dx_in, dy_ff, dy_in, dz_ff, dz_in;
   logic signed [DW-1:0]         tmp_ff, tmp_in;
   logic                         flag_ff, flag_in;
   logic signed [IO_WIDTH-1:0]   px_ff, px_in, py_ff, py_in, pz_ff, pz_in;
   logic                         sat_ff, sat_in;

   logic signed [RW-1:0]  rho_s;
   logic signed [OW-1:0]  op_a, op_b;
   shift_type             shift_sel;
   logic signed [DW-1:0]  mul_res;
   logic signed [DW:0]    sub_a, sub_b, diff, add_base, sum;
   logic signed [DW:0]    lx, ly, lz;
   logic signed [LW-1:0]  x_wide, y_wide, z_wide;

   // rho brought to the state's fraction width
   assign rho_s = (RW'(rho_ff) <<< RSH_L) >>> RSH_R;

   assign lx = (DW + 1)'(req_load_x);
   assign ly = (DW + 1)'(req_load_y);
   assign lz = (DW + 1)'(req_load_z);

   assign x_wide = LW'(x_ff);
   assign y_wide = LW'(y_ff);
   assign z_wide = LW'(z_ff);

   // operand selection for the multiply being launched
   always_comb begin
      case (cmd.op)
         OP_DX: begin
            op_a = OW'(sigma_ff);
            op_b = OW'(y_ff) - OW'(x_ff);
            shift_sel = SH_COEF;
         end
         OP_PXR: begin
            op_a = OW'(x_ff);
            op_b = OW'(rho_s) - OW'(z_ff);
            shift_sel = SH_FRAC;
         end
         OP_PXY: begin
            op_a = OW'(x_ff);
            op_b = OW'(y_ff);
            shift_sel = SH_FRAC;
         end
         OP_BZ: begin
            op_a = OW'(beta_ff);
            op_b = OW'(z_ff);
            shift_sel = SH_COEF;
         end
         OP_HX: begin
            op_a = signed'(OW'(step_ff));
            op_b = OW'(dx_ff);
            shift_sel = SH_STEP;
         end
         OP_HY: begin
            op_a = signed'(OW'(step_ff));
            op_b = OW'(dy_ff);
            shift_sel = SH_STEP;
         end
         default: begin
            op_a = signed'(OW'(step_ff));
            op_b = OW'(dz_ff);
            shift_sel = SH_STEP;
         end
      endcase
   end

   lae_mul #(
      .OW        (OW),
      .DW        (DW),
      .FRAC_BITS (FRAC_BITS)
   ) u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.mul_start),
      .shift  (shift_sel),
      .op_a   (op_a),
      .op_b   (op_b),
      .busy   (status.mul_busy),
      .done   (status.mul_done),
      .result (mul_res)
   );

   // write-back arithmetic: one subtract for dy and dz, one add for the step
   always_comb begin
      sub_a = (cmd.op == OP_BZ) ? (DW + 1)'(tmp_ff)  : (DW + 1)'(mul_res);
      sub_b = (cmd.op == OP_BZ) ? (DW + 1)'(mul_res) : (DW + 1)'(y_ff);
      diff  = sub_a - sub_b;
      case (cmd.op)
         OP_HX:   add_base = (DW + 1)'(x_ff);
         OP_HY:   add_base = (DW + 1)'(y_ff);
         default: add_base = (DW + 1)'(z_ff);
      endcase
      sum = add_base + (DW + 1)'(mul_res);
   end

   always_comb begin
      sigma_in = sigma_ff;
      rho_in   = rho_ff;
      beta_in  = beta_ff;
      step_in  = step_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_SIGMA: sigma_in = signed'(csr_wr_data);
            CSR_RHO:   rho_in   = signed'(csr_wr_data);
            CSR_BETA:  beta_in  = signed'(csr_wr_data);
            CSR_STEP:  step_in  = csr_wr_data[STEP_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      nx_in   = nx_ff;
      ny_in   = ny_ff;
      dx_in   = dx_ff;
      dy_in   = dy_ff;
      dz_in   = dz_ff;
      tmp_in  = tmp_ff;
      flag_in = flag_ff;
      px_in   = px_ff;
      py_in   = py_ff;
      pz_in   = pz_ff;
      sat_in  = sat_ff;
      if (cmd.accept) begin
         flag_in = 1'b0;
         case (cmd.mode)
            MODE_LOAD: begin
               x_in    = clamp_sw(lx);
               y_in    = clamp_sw(ly);
               z_in    = clamp_sw(lz);
               flag_in = !fits_sw(lx) || !fits_sw(ly) || !fits_sw(lz);
            end
            MODE_RESTART: begin
               x_in = START_X;
               y_in = '0;
               z_in = '0;
            end
            default: ;
         endcase
      end
      if (cmd.write) begin
         case (cmd.op)
            OP_DX:  dx_in  = mul_res;
            OP_PXR: dy_in  = clamp_dw(diff);
            OP_PXY: tmp_in = mul_res;
            OP_BZ:  dz_in  = clamp_dw(diff);
            OP_HX: begin
               nx_in   = clamp_sw(sum);
               flag_in = flag_ff || !fits_sw(sum);
            end
            OP_HY: begin
               ny_in   = clamp_sw(sum);
               flag_in = flag_ff || !fits_sw(sum);
            end
            OP_HZ: begin
               x_in    = nx_ff;
               y_in    = ny_ff;
               z_in    = clamp_sw(sum);
               flag_in = flag_ff || !fits_sw(sum);
            end
            default: ;
         endcase
      end
      if (cmd.publish) begin
         px_in  = x_wide[IO_WIDTH-1:0];
         py_in  = y_wide[IO_WIDTH-1:0];
         pz_in  = z_wide[IO_WIDTH-1:0];
         sat_in = flag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sigma_ff <= signed'(SIGMA_RESET);
         rho_ff   <= signed'(RHO_RESET);
         beta_ff  <= signed'(BETA_RESET);
         step_ff  <= STEP_RESET;
         x_ff     <= START_X;
         y_ff     <= '0;
         z_ff     <= '0;
      end else begin
         sigma_ff <= sigma_in;
         rho_ff   <= rho_in;
         beta_ff  <= beta_in;
         step_ff  <= step_in;
         x_ff     <= x_in;
         y_ff     <= y_in;
         z_ff     <= z_in;
      end
   end

   always_ff @(posedge clock) begin
      nx_ff   <= nx_in;
      ny_ff   <= ny_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      dz_ff   <= dz_in;
      tmp_ff  <= tmp_in;
      flag_ff <= flag_in;
      px_ff   <= px_in;
      py_ff   <= py_in;
      pz_ff   <= pz_in;
      sat_ff  <= sat_in;
   end

   assign rsp_pos_x     = px_ff;
   assign rsp_pos_y     = py_ff;
   assign rsp_pos_z     = pz_ff;
   assign rsp_saturated = sat_ff;

endmodule

@@ rtl/lae_ctrl.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lae_ctrl: item sequencer
// Takes one word at a time, walks the seven multiplies of a tick and hands
// the result to the output register.
// -----------------------------------------------------------------------------
module lae_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [1:0]            req_mode,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output lae_pkg::cmd_type      cmd,
   input  lae_pkg::status_type   status
);
   import lae_pkg::*;

   ctrl_state_type state_ff, state_in;
   op_type         step_ff, step_in;
   logic           rsp_valid_ff, rsp_valid_in;

   // next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (mode_type'(req_mode) == MODE_TICK) begin
                  state_in = ST_START;
                  step_in  = OP_DX;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_START: state_in = ST_WAIT;
         ST_WAIT: begin
            if (status.mul_done) begin
               if (step_ff == OP_HZ) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_START;
                  step_in  = op_type'(step_ff + 1'b1);
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = cmd.publish || (rsp_valid_ff && rsp_stall);
   end

   // outputs
   always_comb begin
      req_stall     = (state_ff != ST_IDLE);
      cmd.accept    = (state_ff == ST_IDLE) && req_valid;
      cmd.mode      = mode_type'(req_mode);
      cmd.mul_start = (state_ff == ST_START);
      cmd.write     = (state_ff == ST_WAIT) && status.mul_done;
      cmd.op        = step_ff;
      cmd.publish   = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= OP_DX;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/lorenz_attractor_euler.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lorenz_attractor_euler: Lorenz oscillator, one forward Euler step per word
// Chaotic x, y, z state in signed fixed point, coefficient registers and a
// shared multiplier sequenced by a small controller.
// -----------------------------------------------------------------------------
// Usage
//   Request channel (req_valid / req_stall): one word per item. req_mode
//   selects a tick (one Euler step), a load of req_load_x/y/z, or a return
//   to the start point (0.5, 0, 0); the unused code holds the state.
//   Response channel (rsp_valid / rsp_stall): one word per item with x, y, z
//   after the item and rsp_saturated, set when a state value was clipped.
//   CSR port: csr_wr_en writes csr_wr_data into sigma, rho, beta or step
//   size selected by csr_index; write only while no item is in flight.
//   Steps: load, return and hold go from acceptance to the done state,
//   which places the word in the output register. A tick runs seven
//   multiplies through the one 16-bit-digit multiplier, each as launch,
//   ND digits, floor, clip and write-back with ND = ceil(OW / 16), and
//   then reaches the done state.
//   One item is worked at a time; req_stall stays high until its word sits
//   in the output register, so the next item is taken while that word waits.
//   A stalled receiver holds the output word; a finished item then waits.
//   Reset (synchronous) restores the registers and the start point and
//   drops any word in flight.
// -----------------------------------------------------------------------------
module lorenz_attractor_euler #(
   parameter int FRAC_BITS   = lae_pkg::FRAC_BITS_DEF,
   parameter int STATE_WIDTH = lae_pkg::STATE_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [1:0]                             req_mode,
   input  logic signed [lae_pkg::IO_WIDTH-1:0]    req_load_x,
   input  logic signed [lae_pkg::IO_WIDTH-1:0]    req_load_y,
   input  logic signed [lae_pkg::IO_WIDTH-1:0]    req_load_z,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [lae_pkg::IO_WIDTH-1:0]    rsp_pos_x,
   output logic signed [lae_pkg::IO_WIDTH-1:0]    rsp_pos_y,
   output logic signed [lae_pkg::IO_WIDTH-1:0]    rsp_pos_z,
   output logic                                   rsp_saturated,
   input  logic                                   csr_wr_en,
   input  logic [lae_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [lae_pkg::COEF_WIDTH-1:0]         csr_wr_data
);
   import lae_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer: decides what happens in each cycle
   lae_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // state, registers, multiplier and output word
   lae_datapath #(
      .FRAC_BITS   (FRAC_BITS),
      .STATE_WIDTH (STATE_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data),
      .req_load_x    (req_load_x),
      .req_load_y    (req_load_y),
      .req_load_z    (req_load_z),
      .rsp_pos_x     (rsp_pos_x),
      .rsp_pos_y     (rsp_pos_y),
      .rsp_pos_z     (rsp_pos_z),
      .rsp_saturated (rsp_saturated)
   );

   // never overwrite a word the receiver has not taken
   a_publish_free : assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> (!rsp_valid || !rsp_stall))
      else $error("result published over a held output word");

   // the shared multiplier is launched only when idle
   a_start_idle : assert property (@(posedge clock) disable iff (reset)
      cmd.mul_start |-> !status.mul_busy)
      else $error("multiplier restarted while busy");

   // a new item finds the multiplier quiet
   a_accept_quiet : assert property (@(posedge clock) disable iff (reset)
      cmd.accept |-> (!status.mul_busy && !status.mul_done))
      else $error("item accepted while a multiply is in flight");

endmodule

@@ bench/lorenz_attractor_euler_tb.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lorenz_attractor_euler_tb: self-checking bench for the Lorenz oscillator
// Drives ticks, state loads, returns to the start point and the spare hold
// code under bursty input and a stalling receiver. Every response word is
// compared with a fixed-point Euler predictor kept in step with the CSRs.
// -----------------------------------------------------------------------------
module lorenz_attractor_euler_tb;
   import lae_pkg::*;

   // The spare mode code: the block holds its state and clears the flag.
   localparam logic [1:0] MODE_HOLD = 2'd3;

   localparam int FRAC    = FRAC_BITS_DEF;
   localparam int STATE_W = STATE_WIDTH_DEF;
   localparam int DERIV_W = STATE_WIDTH_DEF + GUARD_BITS;

   typedef struct packed {
      logic [IO_WIDTH-1:0] x;
      logic [IO_WIDTH-1:0] y;
      logic [IO_WIDTH-1:0] z;
      logic                sat;
   } lorenz_word_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [1:0]                 req_mode = MODE_TICK;
   logic signed [IO_WIDTH-1:0] req_load_x = '0;
   logic signed [IO_WIDTH-1:0] req_load_y = '0;
   logic signed [IO_WIDTH-1:0] req_load_z = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [IO_WIDTH-1:0] rsp_pos_x;
   logic signed [IO_WIDTH-1:0] rsp_pos_y;
   logic signed [IO_WIDTH-1:0] rsp_pos_z;
   logic                       rsp_saturated;
   logic                       csr_wr_en = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = CSR_SIGMA;
   logic [COEF_WIDTH-1:0]      csr_wr_data = '0;

   // Predictor copy of the registers and the orbit, at their reset values.
   logic signed [COEF_WIDTH-1:0] coef_sigma = SIGMA_RESET;
   logic signed [COEF_WIDTH-1:0] coef_rho   = RHO_RESET;
   logic signed [COEF_WIDTH-1:0] coef_beta  = BETA_RESET;
   logic [STEP_WIDTH-1:0]        coef_step  = STEP_RESET;
   longint orbit_x = longint'(1) << (FRAC - 1);
   longint orbit_y = 0;
   longint orbit_z = 0;

   lorenz_word_type pending_positions[$];
   lorenz_word_type due_word;
   int error_count = 0;
   int items_sent = 0;
   int burst_left = 0;
   int hold_off_asked = 0;
   int hold_left = 0;
   int stall_style = 0;
   int style_left = 0;

   lorenz_attractor_euler dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mode      (req_mode),
      .req_load_x    (req_load_x),
      .req_load_y    (req_load_y),
      .req_load_z    (req_load_z),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_pos_x     (rsp_pos_x),
      .rsp_pos_y     (rsp_pos_y),
      .rsp_pos_z     (rsp_pos_z),
      .rsp_saturated (rsp_saturated),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Give up long after the slowest legal run would have finished.
   initial begin
      #(10_000_000);
      $display("lorenz_attractor_euler_tb: errors");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------

   // Clip to the signed w-bit range.
   function automatic longint clip_signed(input longint v, input int w);
      longint hi_lim;
      hi_lim = (longint'(1) << (w - 1)) - 1;
      if (v > hi_lim) return hi_lim;
      if (v < -hi_lim - 1) return -hi_lim - 1;
      return v;
   endfunction

   // floor(a * b / 2^sh), clipped to signed w bits; the product is kept whole.
   function automatic longint scaled_product(input longint a, input longint b,
                                             input int sh, input int w);
      logic signed [127:0] wa;
      logic signed [127:0] wb;
      logic signed [127:0] wide;
      logic signed [127:0] hi_lim;
      wa = 128'(a);
      wb = 128'(b);
      wide = (wa * wb) >>> sh;
      hi_lim = 128'sd1;
      hi_lim = (hi_lim << (w - 1)) - 128'sd1;
      if (wide > hi_lim) return hi_lim[63:0];
      if (wide < -hi_lim - 128'sd1) begin
         wide = -hi_lim - 128'sd1;
      end
      return wide[63:0];
   endfunction

   // Apply one item to the orbit and return the word the block must publish.
   function automatic lorenz_word_type advance_lorenz(input logic [1:0] mode,
                                                      input logic signed [31:0] lx,
                                                      input logic signed [31:0] ly,
                                                      input logic signed [31:0] lz);
      lorenz_word_type w;
      bit clipped;
      longint sg, rh, bt, hh, r, dx, dy, dz, p, q, raw_x, raw_y, raw_z;
      clipped = 1'b0;
      case (mode)
         MODE_TICK: begin
            sg = longint'(coef_sigma);
            rh = longint'(coef_rho);
            bt = longint'(coef_beta);
            hh = longint'(coef_step);
            // Bring rho onto the state's fraction point.
            if (FRAC >= COEF_FRAC) begin
               r = rh <<< (FRAC - COEF_FRAC);
            end else begin
               r = rh >>> (COEF_FRAC - FRAC);
            end
            // Derivatives from the old state; their own clipping is silent.
            dx = scaled_product(sg, orbit_y - orbit_x, COEF_FRAC, DERIV_W);
            p  = scaled_product(orbit_x, r - orbit_z, FRAC, DERIV_W);
            dy = clip_signed(p - orbit_y, DERIV_W);
            p  = scaled_product(orbit_x, orbit_y, FRAC, DERIV_W);
            q  = scaled_product(bt, orbit_z, COEF_FRAC, DERIV_W);
            dz = clip_signed(p - q, DERIV_W);
            raw_x = orbit_x + scaled_product(hh, dx, STEP_FRAC, DERIV_W);
            raw_y = orbit_y + scaled_product(hh, dy, STEP_FRAC, DERIV_W);
            raw_z = orbit_z + scaled_product(hh, dz, STEP_FRAC, DERIV_W);
            orbit_x = clip_signed(raw_x, STATE_W);
            orbit_y = clip_signed(raw_y, STATE_W);
            orbit_z = clip_signed(raw_z, STATE_W);
            clipped = (orbit_x != raw_x) || (orbit_y != raw_y) || (orbit_z != raw_z);
         end
         MODE_LOAD: begin
            raw_x = longint'(lx);
            raw_y = longint'(ly);
            raw_z = longint'(lz);
            orbit_x = clip_signed(raw_x, STATE_W);
            orbit_y = clip_signed(raw_y, STATE_W);
            orbit_z = clip_signed(raw_z, STATE_W);
            clipped = (orbit_x != raw_x) || (orbit_y != raw_y) || (orbit_z != raw_z);
         end
         MODE_RESTART: begin
            orbit_x = longint'(1) << (FRAC - 1);
            orbit_y = 0;
            orbit_z = 0;
         end
         default: begin
            // Hold: the orbit stays where it is.
         end
      endcase
      w.x = orbit_x[31:0];
      w.y = orbit_y[31:0];
      w.z = orbit_z[31:0];
      w.sat = clipped;
      return w;
   endfunction

   // ---------------------------------------------------------------------------
   // Response side: check each accepted word, then pick the next stall value
   // ---------------------------------------------------------------------------

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_positions.size() == 0) begin
            $display("%0t: word with nothing expected, actual %h %h %h %b", $time,
                     rsp_pos_x, rsp_pos_y, rsp_pos_z, rsp_saturated);
            error_count++;
         end else begin
            due_word = pending_positions.pop_front();
            check_field("pos_x", due_word.x, rsp_pos_x);
            check_field("pos_y", due_word.y, rsp_pos_y);
            check_field("pos_z", due_word.z, rsp_pos_z);
            check_field("saturated", {31'd0, due_word.sat}, {31'd0, rsp_saturated});
         end
      end
      // Pick up a requested hold-off and count it down here.
      if (hold_off_asked > 0) begin
         hold_left = hold_off_asked;
         hold_off_asked = 0;
      end
      // Switch the stall style now and then: none, light, heavy.
      if (style_left == 0) begin
         stall_style = $urandom_range(0, 2);
         style_left = $urandom_range(20, 200);
      end else begin
         style_left--;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_style)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------------

   // Offer one word in bursts with random gaps; record its prediction once taken.
   // Valid stays high after acceptance: the next call either reloads it or drops it.
   task automatic send_command(input logic [1:0] mode, input logic [31:0] lx,
                               input logic [31:0] ly, input logic [31:0] lz);
      int gap;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 12);
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150)
                                                  : $urandom_range(1, 10);
      end
      burst_left--;
      req_valid  <= 1'b1;
      req_mode   <= mode;
      req_load_x <= lx;
      req_load_y <= ly;
      req_load_z <= lz;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_positions.push_back(advance_lorenz(mode, lx, ly, lz));
      items_sent++;
   endtask

   // Drop valid and wait until every expected word has come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_positions.size() != 0) @(posedge clock);
   endtask

   // Write all four registers on consecutive edges; call only when idle.
   task automatic program_coefs(input logic [31:0] sg, input logic [31:0] rh,
                                input logic [31:0] bt, input logic [23:0] h);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_SIGMA;
      csr_wr_data <= sg;
      @(posedge clock);
      csr_index   <= CSR_RHO;
      csr_wr_data <= rh;
      @(posedge clock);
      csr_index   <= CSR_BETA;
      csr_wr_data <= bt;
      @(posedge clock);
      csr_index   <= CSR_STEP;
      csr_wr_data <= {8'd0, h};
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      coef_sigma = sg;
      coef_rho   = rh;
      coef_beta  = bt;
      coef_step  = h;
   endtask

   function automatic logic [31:0] pick_extreme();
      case ($urandom_range(0, 4))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Start point after reset, first steps at the reset coefficients.
   task automatic test_power_on();
      send_command(MODE_HOLD, 32'd0, 32'd0, 32'd0);
      send_command(MODE_TICK, 32'd0, 32'd0, 32'd0);
      send_command(MODE_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_command(MODE_RESTART, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
   endtask

   // Field extremes, state clipping, flag clearing on restart and hold.
   task automatic test_corner_words();
      send_command(MODE_LOAD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_command(MODE_TICK, 32'd0, 32'd0, 32'd0);
      send_command(MODE_HOLD, 32'd0, 32'd0, 32'd0);
      send_command(MODE_LOAD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_command(MODE_TICK, 32'd0, 32'd0, 32'd0);
      send_command(MODE_RESTART, 32'd0, 32'd0, 32'd0);
      send_command(MODE_LOAD, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
      send_command(MODE_TICK, 32'd0, 32'd0, 32'd0);
      send_command(MODE_LOAD, 32'd0, 32'd0, 32'd0);
      send_command(MODE_TICK, 32'd0, 32'd0, 32'd0);
      send_command(MODE_LOAD, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
      send_command(MODE_TICK, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
      send_command(MODE_RESTART, 32'd0, 32'd0, 32'd0);
      send_command(MODE_TICK, 32'd0, 32'd0, 32'd0);
   endtask

   // Hold the receiver off for a long stretch while words keep coming, so the
   // output register and the finished item both back up into req_stall.
   task automatic test_output_hold_off();
      drain();
      hold_off_asked = 400;
      repeat (6) begin
         send_command(MODE_TICK, $urandom(), $urandom(), $urandom());
         send_command(MODE_LOAD, $urandom(), $urandom(), $urandom());
      end
      drain();
   endtask

   // Program a setting, then run random sequences: mostly orbits started from
   // the start point or a sane load, the rest wild loads, corners and holds.
   task automatic run_phase(input logic [31:0] sg, input logic [31:0] rh,
                            input logic [31:0] bt, input logic [23:0] h,
                            input int count);
      int start;
      int run_len;
      start = items_sent;
      drain();
      program_coefs(sg, rh, bt, h);
      while (items_sent - start < count) begin
         run_len = $urandom_range(5, 40);
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               send_command(MODE_RESTART, $urandom(), $urandom(), $urandom());
            end
            3, 4, 5: begin
               send_command(MODE_LOAD,
                            int'($urandom_range(0, 32'd104857600)) - 52428800,
                            int'($urandom_range(0, 32'd104857600)) - 52428800,
                            int'($urandom_range(0, 32'd104857600)) - 52428800);
            end
            6: begin
               send_command(MODE_LOAD, $urandom(), $urandom(), $urandom());
               run_len = $urandom_range(1, 4);
            end
            7: begin
               send_command(MODE_LOAD, pick_extreme(), pick_extreme(), pick_extreme());
               run_len = $urandom_range(1, 4);
            end
            8: begin
               send_command(MODE_HOLD, $urandom(), $urandom(), $urandom());
               run_len = $urandom_range(0, 2);
            end
            default: begin
               // Carry on along the current orbit.
            end
         endcase
         repeat (run_len) send_command(MODE_TICK, $urandom(), $urandom(), $urandom());
      end
   endtask

   task automatic test_coefficient_sweep();
      run_phase(SIGMA_RESET, RHO_RESET, BETA_RESET, STEP_RESET, 350);
      // Zero step: ticks must leave the orbit alone.
      run_phase(SIGMA_RESET, RHO_RESET, BETA_RESET, 24'd0, 60);
      run_phase(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'hFF_FFFF, 60);
      run_phase(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 24'hFF_FFFF, 60);
      run_phase(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 24'd1, 40);
      repeat (3) begin
         run_phase($urandom(), $urandom(), $urandom(),
                   24'($urandom_range(0, 24'hFF_FFFF)), 80);
      end
      // Classic chaotic region with a coarse step to stir the orbit.
      run_phase($urandom_range(32'd5242880, 32'd15728640),
                $urandom_range(32'd20971520, 32'd41943040),
                $urandom_range(32'd1048576, 32'd4194304),
                24'($urandom_range(20000, 300000)), 250);
      run_phase(SIGMA_RESET, RHO_RESET, BETA_RESET, STEP_RESET, 150);
   endtask

   // ---------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_power_on();
      test_corner_words();
      test_output_hold_off();
      test_coefficient_sweep();
      drain();
      // Allow a full tick's latency for any stray word.
      repeat (60) @(posedge clock);
      if (error_count == 0) begin
         $display("lorenz_attractor_euler_tb: clean");
      end else begin
         $display("lorenz_attractor_euler_tb: errors");
      end
      $finish;
   end

endmodule
